// ----- hdl/lpht_pkg.sv -----
// Shared types and constants for the linear-probe hash table.
`timescale 1ns / 1ps

package lpht_pkg;

   localparam int KEY_W          = 31;
   localparam int VAL_W          = 32;
   localparam int STATUS_W       = 3;
   localparam int DEF_TABLE_SIZE = 32;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic                    op;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [VAL_W-1:0] read_value;
   } rsp_type;

endpackage

// ----- hdl/lpht_rem.sv -----
// Home-slot unit: key mod table size (low bits, or reciprocal multiply).
`timescale 1ns / 1ps

module lpht_rem #(
   parameter int TABLE_SIZE = lpht_pkg::DEF_TABLE_SIZE
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lpht_pkg::KEY_W-1:0]    key,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] rem
);
   import lpht_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam bit POW2   = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam int SHIFT  = KEY_W + IDX_W;
   localparam int PROD_W = KEY_W + 32;
   // Rounded-up reciprocal: gives the exact quotient for every KEY_W-bit key.
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [31:0]      RECIP   = RECIP_FULL[31:0];
   localparam logic [IDX_W-1:0] SIZE_LO = IDX_W'(TABLE_SIZE);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [IDX_W-1:0]  key_lo_ff, key_lo_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  quot_lo;
   logic [IDX_W-1:0]  back_lo;

   // The remainder is below the table size, so only the low bits of the
   // quotient times the size are needed to correct the key.
   assign quot_lo = prod_ff[SHIFT +: IDX_W];
   assign back_lo = quot_lo * SIZE_LO;

   always_comb begin
      busy_in   = 1'b0;
      done_in   = 1'b0;
      prod_in   = prod_ff;
      key_lo_in = key_lo_ff;
      rem_in    = rem_ff;
      if (start) begin
         key_lo_in = key[IDX_W-1:0];
         if (POW2) begin
            rem_in  = key[IDX_W-1:0];
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            prod_in = PROD_W'(key) * PROD_W'(RECIP);
         end
      end else if (busy_ff) begin
         rem_in  = key_lo_ff - back_lo;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prod_ff   <= prod_in;
      key_lo_ff <= key_lo_in;
      rem_ff    <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

// ----- hdl/linear_probe_hash_table_unit.sv -----
// Top level of the linear-probe hash table: sequencer, slot memory, result register.
`timescale 1ns / 1ps

// Open-addressing key/value store with linear probing. Each request is a put
// (insert or update) or a get (lookup); each returns exactly one response with
// a status and, for a found get, the stored value. Requests are handled one at
// a time. After reset the block runs a clearing pass over every slot of the
// slot memory, during which req_stall is high. A request probes from 1 to
// TABLE_SIZE slots. Each probe of the slot memory is a registered read followed
// by the key compare. For sizes that are not a power of two the home slot unit
// adds a registered step: it forms key mod TABLE_SIZE by multiplying with a
// reciprocal of the table size and then correcting the low bits. A finished
// response waits in an output register, so the next request is taken while
// the previous response is still stalled.

module linear_probe_hash_table_unit #(
   parameter int TABLE_SIZE = lpht_pkg::DEF_TABLE_SIZE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpht_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpht_pkg::rsp_type rsp_payload
);
   import lpht_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SIZE - 1);

   typedef struct packed {
      logic                    valid;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
   } entry_type;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_HASH  = 5'b00100,
      S_READ  = 5'b01000,
      S_CHECK = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   req_type          cur_ff, cur_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   entry_type        rd_data_ff;

   entry_type        mem [TABLE_SIZE];
   logic             wr_en;
   entry_type        wr_data;

   logic             req_take;
   logic             rsp_free;
   logic             rsp_load;
   logic             hash_done;
   logic [IDX_W-1:0] hash_slot;
   logic             slot_hit;
   logic             slot_empty;
   logic             lap_done;
   logic [IDX_W-1:0] pos_next;

   // Take a request only while idle; the response register has its own handshake.
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   lpht_rem #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_rem (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .key   (req_payload.key),
      .done  (hash_done),
      .rem   (hash_slot)
   );

   // Probe outcome, valid while in S_CHECK.
   assign slot_empty = !rd_data_ff.valid;
   assign slot_hit   = rd_data_ff.valid && (rd_data_ff.key == cur_ff.key);
   assign lap_done   = (cnt_ff == LAST_SLOT);
   assign pos_next   = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      rsp_load = 1'b0;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_data  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep every slot and drop its valid mark.
            wr_en  = 1'b1;
            pos_in = pos_next;
            if (pos_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               cur_in   = req_payload;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            // Start the walk at the home slot.
            if (hash_done) begin
               pos_in   = hash_slot;
               cnt_in   = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // The memory read of pos_ff lands in rd_data_ff at this edge.
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (slot_hit || slot_empty || lap_done) begin
               // Hold here until the response register is free.
               if (rsp_free) begin
                  rsp_load            = 1'b1;
                  rsp_in.read_value   = '0;
                  state_in            = S_IDLE;
                  if (cur_ff.op == OP_PUT) begin
                     if (slot_hit) begin
                        rsp_in.status = ST_UPDATED;
                        wr_en         = 1'b1;
                     end else if (slot_empty) begin
                        rsp_in.status = ST_INSERTED;
                        wr_en         = 1'b1;
                     end else begin
                        rsp_in.status = ST_FULL;
                     end
                     wr_data.valid = 1'b1;
                     wr_data.key   = cur_ff.key;
                     wr_data.value = cur_ff.value;
                  end else begin
                     if (slot_hit) begin
                        rsp_in.status     = ST_FOUND;
                        rsp_in.read_value = rd_data_ff.value;
                     end else begin
                        rsp_in.status = ST_NOT_FOUND;
                     end
                  end
               end
            end else begin
               // Advance to the next slot, wrapping at the end of the table.
               pos_in   = pos_next;
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_CLEAR;
            pos_in   = '0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // Slot memory: one write port and one registered read port, both at pos_ff.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      rd_data_ff <= mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // A response never overwrites one that is still stalled.
   a_rsp_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("response loaded while previous one still stalled");

   // An accepted request always moves on to the home slot computation.
   a_take_to_hash : assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_HASH))
      else $error("accepted request did not enter hashing");

   // Only a put can report a full table, and a full table writes nothing.
   a_full_is_put : assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (rsp_in.status == ST_FULL)) |-> ((cur_ff.op == OP_PUT) && !wr_en))
      else $error("full status on a get or with a write");

   // The memory is written only by the clearing pass or at the end of a put.
   a_write_source : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == S_CLEAR) || (rsp_load && (cur_ff.op == OP_PUT))))
      else $error("slot memory written outside clear or put completion");

   // A get never writes a slot.
   a_get_no_write : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CHECK) && (cur_ff.op == OP_GET)) |-> !wr_en)
      else $error("get wrote the slot memory");
`endif

endmodule

// ----- sim/lpht_checker.sv -----
// Checker for the hash table unit: predicts each response and compares it.
`timescale 1ns / 1ps

module lpht_checker #(
   parameter int TABLE_SIZE = lpht_pkg::DEF_TABLE_SIZE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lpht_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lpht_pkg::rsp_type rsp_payload,
   output int                outstanding,
   output int                fail_count
);

   import lpht_pkg::*;

   logic             slot_used [TABLE_SIZE];
   logic [KEY_W-1:0] slot_key  [TABLE_SIZE];
   logic [VAL_W-1:0] slot_val  [TABLE_SIZE];
   rsp_type          expected_q [$];
   int               errors = 0;

   // Probe from the home slot, then apply the request to the shadow table.
   function automatic rsp_type apply_request(input req_type r);
      int      pos;
      logic    stop;
      logic    hit;
      rsp_type res;
      pos  = int'(r.key % TABLE_SIZE);
      stop = 1'b0;
      hit  = 1'b0;
      for (int n = 0; n < TABLE_SIZE && !stop; n++) begin
         if (!slot_used[pos]) begin
            stop = 1'b1;
         end else if (slot_key[pos] == r.key) begin
            stop = 1'b1;
            hit  = 1'b1;
         end else begin
            pos = (pos + 1) % TABLE_SIZE;
         end
      end
      res = '0;
      if (r.op == OP_PUT) begin
         if (!stop) begin
            res.status = ST_FULL;
         end else begin
            res.status     = hit ? ST_UPDATED : ST_INSERTED;
            slot_used[pos] = 1'b1;
            slot_key[pos]  = r.key;
            slot_val[pos]  = r.value;
         end
      end else if (hit) begin
         res.status     = ST_FOUND;
         res.read_value = slot_val[pos];
      end else begin
         res.status = ST_NOT_FOUND;
      end
      return res;
   endfunction

   task automatic note_failure(input string msg);
      errors++;
      if (errors <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SIZE; i++) begin
            slot_used[i] = 1'b0;
         end
         expected_q.delete();
      end else begin
         // Compare first: a response never belongs to the request taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               note_failure($sformatf("unexpected response status=%0d read_value=%h",
                                      rsp_payload.status, rsp_payload.read_value));
            end else begin
               want = expected_q.pop_front();
               if (rsp_payload.status !== want.status ||
                   rsp_payload.read_value !== want.read_value) begin
                  note_failure($sformatf(
                     "mismatch: expected status=%0d read_value=%h, got status=%0d read_value=%h",
                     want.status, want.read_value,
                     rsp_payload.status, rsp_payload.read_value));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(apply_request(req_payload));
         end
      end
      outstanding <= expected_q.size();
      fail_count  <= errors;
   end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the hash table unit: clock, reset, request and response drivers, verdict.
`timescale 1ns / 1ps

module tb;

   import lpht_pkg::*;

   localparam int RANDOM_ITEMS = 1730;
   localparam int HOLD_AT      = 2000;    // receiver cycle at which the long hold starts
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 100;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   int      outstanding;
   int      fail_count;

   // Keys already offered as puts; updates and most gets draw from here.
   logic [KEY_W-1:0] known_keys [$];
   int               sent   = 0;
   logic             steady = 1'b0;

   always #5 clock = ~clock;

   linear_probe_hash_table_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   lpht_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   // Draw a key over the full 31 bits; a quarter of them land on the last home
   // slot so that probe chains pile up there and wrap round to slot 0.
   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      k = KEY_W'($urandom);
      if ($urandom_range(0, 3) == 0) begin
         k = KEY_W'((k / DEF_TABLE_SIZE) * DEF_TABLE_SIZE + DEF_TABLE_SIZE - 1);
      end
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] known_key();
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
   endfunction

   // Offer one request and hold it until the unit takes it. Called at a rising
   // edge; leaves at the edge where the request was accepted.
   task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value);
      req_type r;
      int      gap;
      int      pick;
      r.op    = op;
      r.key   = key;
      r.value = value;
      if (op == OP_PUT) begin
         known_keys.push_back(key);
      end
      // Every 64 requests, choose whether the next run goes back to back.
      if (sent % 64 == 0) begin
         steady = ($urandom_range(0, 3) == 0);
      end
      gap  = 0;
      pick = $urandom_range(0, 99);
      if (!steady) begin
         if (pick >= 97) begin
            gap = $urandom_range(20, 60);
         end else if (pick >= 60) begin
            gap = $urandom_range(1, 4);
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   // Request side: reset, a directed opening, then random traffic.
   initial begin : stimulus
      int pick;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Lookup in the empty table.
      send_request(OP_GET, 31'd5, 32'h0000_0000);
      // Insert at the smallest and largest keys with extreme values.
      send_request(OP_PUT, 31'd0, 32'h7FFF_FFFF);
      send_request(OP_PUT, 31'h7FFF_FFFF, 32'h8000_0000);
      // Same home slot as the largest key: probe wraps past the occupied slot 0.
      send_request(OP_PUT, 31'h7FFF_FFDF, 32'hFFFF_FFFF);
      // Value field must be ignored on a get.
      send_request(OP_GET, 31'h7FFF_FFDF, 32'h1234_5678);
      send_request(OP_GET, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET, 31'd0, 32'h0000_0000);
      // Updates in place.
      send_request(OP_PUT, 31'd0, 32'hFFFF_FFFF);
      send_request(OP_GET, 31'd0, 32'h0000_0000);
      send_request(OP_PUT, 31'd0, 32'h0000_0000);
      send_request(OP_GET, 31'd0, 32'h8000_0000);
      // Absent key whose chain runs through the cluster to an empty slot.
      send_request(OP_GET, 31'd32, 32'h0000_0000);
      send_request(OP_PUT, 31'd32, 32'h8000_0000);
      send_request(OP_GET, 31'd32, 32'h7FFF_FFFF);
      send_request(OP_PUT, 31'd32, 32'h7FFF_FFFF);
      send_request(OP_GET, 31'h5555_5555, 32'hAAAA_AAAA);
      send_request(OP_PUT, 31'h2AAA_AAAA, 32'h5555_5555);
      send_request(OP_GET, 31'h2AAA_AAAA, 32'h0000_0000);
      send_request(OP_PUT, 31'h5555_5555, 32'hAAAA_AAAA);
      send_request(OP_GET, 31'h5555_5555, 32'h5555_5555);

      // Random mix. New keys are rare, so the table fills gradually and then
      // stays full: later puts of new keys report full and misses take a lap.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_request(OP_PUT, fresh_key(), $urandom);
         end else if (pick < 40) begin
            send_request(OP_PUT, known_key(), $urandom);
         end else if (pick < 88) begin
            send_request(OP_GET, known_key(), $urandom);
         end else begin
            send_request(OP_GET, fresh_key(), $urandom);
         end
      end
      req_valid <= 1'b0;

      // Let the last prediction register, drain, then watch for strays.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Response side: random stalls in short and long bursts, calm stretches
   // with none, and one long hold that backs the unit up into its input.
   initial begin : response_side
      int cycles;
      int stall_left;
      int pick;
      logic calm;
      cycles     = 0;
      stall_left = 0;
      calm       = 1'b0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (cycles == HOLD_AT) begin
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && cycles % 256 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         if (stall_left == 0 && !calm) begin
            pick = $urandom_range(0, 99);
            if (pick >= 96) begin
               stall_left = $urandom_range(10, 40);
            end else if (pick >= 70) begin
               stall_left = $urandom_range(1, 3);
            end
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) begin
            stall_left--;
         end
         @(posedge clock);
         cycles++;
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
